### rtl/core/pn_pkg.sv
// Shared types and constants of the path normalizer.
`default_nettype none

package pn_pkg;

	localparam logic [7:0] SLASH = 8'd47;
	localparam logic [7:0] DOT   = 8'd46;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam int CFG_WIDTH = 13;
	localparam int LEN_WIDTH = 12;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_NAME_LONG  = 2'd1,
		STAT_OVERFLOW   = 2'd2,
		STAT_INPUT_LONG = 2'd3
	} status_t;

	// Shape of the component seen so far.
	typedef enum logic [1:0] {
		PAT_EMPTY  = 2'd0,
		PAT_DOT    = 2'd1,
		PAT_DOTDOT = 2'd2,
		PAT_OTHER  = 2'd3
	} dot_pat_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_RELOAD = 5'b00010,
		ST_FIN    = 5'b00100,
		ST_DONE   = 5'b01000,
		ST_RDWAIT = 5'b10000
	} state_t;

endpackage

`default_nettype wire

### rtl/core/pn_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/path_normalizer.sv
// Path normalizer top level: byte-wise lexical path normalization with read-back.
//
// Push path bytes with func = 0, last_byte marking the final one; runs of '/'
// collapse, "." components vanish and ".." pops the previous component if
// there is one that is not itself a kept "..". The normalized path is built
// in place in a byte memory; a second memory holds the stack of component
// starts, whose top entry is mirrored in flops. A byte that closes a ".."
// which pops a component passes through ST_RELOAD, because the new stack top
// comes back from the segment memory through its registered read. After the
// last byte, ST_FIN closes the final component and ST_DONE trims and checks
// the length before the status/length transfer. A read (func = 1) waits in
// ST_RDWAIT for the registered byte-memory read. The output register lets
// the next item be taken while a result still waits; a result that finds it
// occupied holds in its own state until the slot frees. Neither memory is
// cleared after reset; only bytes below the reported length are read back.
`default_nettype none

module path_normalizer #(
	parameter int PATH_CAP   = 4096,
	parameter int NAME_LIMIT = 255
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input item channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           func,
	input  wire logic [7:0]                     path_byte,
	input  wire logic                           last_byte,
	input  wire logic [11:0]                    read_index,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [1:0]                     status,
	output logic      [pn_pkg::LEN_WIDTH-1:0]   norm_length,
	output logic      [7:0]                     out_byte,
	// configuration write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [pn_pkg::CFG_WIDTH-1:0]   output_capacity
);

	localparam int AW        = $clog2(PATH_CAP);
	localparam int FW        = $clog2(PATH_CAP + 1);
	localparam int SEG_DEPTH = PATH_CAP / 2 + 1;
	localparam int SAW       = $clog2(SEG_DEPTH);
	localparam int CNTW      = $clog2(SEG_DEPTH + 1);
	localparam int LW        = $clog2(NAME_LIMIT + 1);
	localparam int SW        = $clog2(PATH_CAP + 2);
	localparam int CW        = (FW > pn_pkg::CFG_WIDTH) ? FW : pn_pkg::CFG_WIDTH;
	localparam int XW        = CW + 1;
	localparam int CAP_RST   = (PATH_CAP < 4096) ? PATH_CAP : 4096;

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	pn_pkg::state_t   st_q, st_n;
	pn_pkg::status_t  err_q, err_n;
	pn_pkg::dot_pat_t pat_q, pat_n;
	logic [CW-1:0]    cap_q;
	logic [FW-1:0]    fill_q, fill_n;
	logic [CNTW-1:0]  cnt_q, cnt_n;
	logic [LW-1:0]    len_q, len_n;
	logic [SW-1:0]    seen_q, seen_n;
	logic [FW-1:0]    final_q, final_n;
	logic             abs_q, abs_n;
	logic             first_q, first_n;

	// stack top mirror, last flag, read hit
	logic [FW-1:0]    top_start_q;
	logic             top_dd_q;
	logic             last_q;
	logic             rd_hit_q;

	// output register
	logic                         out_valid_q;
	pn_pkg::status_t              status_q;
	logic [pn_pkg::LEN_WIDTH-1:0] norm_len_q;
	logic [7:0]                   out_byte_q;
	logic                         out_free;
	logic                         out_load;
	pn_pkg::status_t              ld_status;
	logic [pn_pkg::LEN_WIDTH-1:0] ld_len;
	logic [7:0]                   ld_byte;

	// memory ports
	logic            st_we, st_re;
	logic [AW-1:0]   st_waddr, st_raddr;
	logic [7:0]      st_wdata, st_rdata;
	logic            sk_we, sk_re;
	logic [SAW-1:0]  sk_waddr, sk_raddr;
	logic [FW:0]     sk_wdata, sk_rdata;

	// input decode and path-start view of the state
	logic             acc, acc_push, acc_read, is_slash;
	pn_pkg::status_t  b_err, err_a;
	pn_pkg::dot_pat_t b_pat;
	logic [FW-1:0]    b_fill;
	logic [CNTW-1:0]  b_cnt;
	logic [LW-1:0]    b_len;
	logic [SW-1:0]    b_seen, seen_inc;
	logic             b_abs, over, do_char;
	logic [XW-1:0]    char_pos;
	logic [LW-1:0]    len_inc;

	// component close
	logic             ec_en, ec_sel_fin, ec_abs, ec_skip, ec_dd, ec_root, ec_pop, ec_ovf;
	logic             do_pop, do_ovf, do_app;
	logic [FW-1:0]    ec_fill;
	logic [CNTW-1:0]  ec_cnt;
	logic [LW-1:0]    ec_len;
	pn_pkg::dot_pat_t ec_pat;
	pn_pkg::status_t  ec_err;
	logic [XW-1:0]    ec_sum;

	// finish
	logic [FW-1:0]    trim_fill;
	pn_pkg::status_t  done_err;

	assign cfg_ready = 1'b1;
	assign in_stall  = (st_q != pn_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	assign acc      = in_valid && !in_stall;
	assign acc_push = acc && (func == pn_pkg::FUNC_PUSH);
	assign acc_read = acc && (func == pn_pkg::FUNC_READ);
	assign is_slash = (path_byte == pn_pkg::SLASH);

	// A new path starts from cleared counters; the first byte decides rooting.
	assign b_abs  = first_q ? is_slash : abs_q;
	assign b_fill = first_q ? (is_slash ? FW'(1) : FW'(0)) : fill_q;
	assign b_cnt  = first_q ? '0 : cnt_q;
	assign b_len  = first_q ? '0 : len_q;
	assign b_pat  = first_q ? pn_pkg::PAT_EMPTY : pat_q;
	assign b_err  = first_q ? pn_pkg::STAT_OK : err_q;
	assign b_seen = first_q ? '0 : seen_q;

	assign seen_inc = (b_seen < SW'(PATH_CAP + 1)) ? b_seen + SW'(1) : b_seen;
	assign over     = (seen_inc > SW'(PATH_CAP));
	assign err_a    = (over && b_err == pn_pkg::STAT_OK) ? pn_pkg::STAT_INPUT_LONG : b_err;

	assign do_char  = acc_push && !over && !is_slash && (err_a == pn_pkg::STAT_OK);
	assign char_pos = XW'(b_fill) + XW'(b_len);
	assign len_inc  = b_len + LW'(1);

	// Component close, shared by a '/' byte and the end of the path.
	assign ec_sel_fin = (st_q == pn_pkg::ST_FIN);
	assign ec_en   = (acc_push && !over && is_slash) || ec_sel_fin;
	assign ec_fill = ec_sel_fin ? fill_q : b_fill;
	assign ec_cnt  = ec_sel_fin ? cnt_q  : b_cnt;
	assign ec_len  = ec_sel_fin ? len_q  : b_len;
	assign ec_pat  = ec_sel_fin ? pat_q  : b_pat;
	assign ec_err  = ec_sel_fin ? err_q  : err_a;
	assign ec_abs  = ec_sel_fin ? abs_q  : b_abs;

	assign ec_sum  = XW'(ec_fill) + XW'(ec_len);
	assign ec_skip = (ec_err != pn_pkg::STAT_OK) || (ec_len == '0) || (ec_pat == pn_pkg::PAT_DOT);
	assign ec_dd   = (ec_pat == pn_pkg::PAT_DOTDOT);
	assign ec_root = ec_dd && (ec_cnt == '0) && ec_abs;
	// ".." over a kept ".." stacks up instead of popping
	assign ec_pop  = ec_dd && (ec_cnt != '0) && !top_dd_q;
	assign ec_ovf  = (ec_sum >= XW'(cap_q)) || (ec_cnt >= CNTW'(SEG_DEPTH));

	assign do_pop = ec_en && !ec_skip && !ec_root && ec_pop;
	assign do_ovf = ec_en && !ec_skip && !ec_root && !ec_pop && ec_ovf;
	assign do_app = ec_en && !ec_skip && !ec_root && !ec_pop && !ec_ovf;

	// Trailing '/' drop: every nonzero fill ends just past a '/', so no read needed.
	assign trim_fill = (fill_q > FW'(1)) ? fill_q - FW'(1) : fill_q;
	assign done_err  = (err_q == pn_pkg::STAT_OK && XW'(trim_fill) >= XW'(cap_q))
		? pn_pkg::STAT_OVERFLOW : err_q;

	// ------------------------------------------------------------------
	// Next-state logic
	// ------------------------------------------------------------------
	always_comb begin
		st_n    = st_q;
		err_n   = err_q;
		pat_n   = pat_q;
		fill_n  = fill_q;
		cnt_n   = cnt_q;
		len_n   = len_q;
		seen_n  = seen_q;
		final_n = final_q;
		abs_n   = abs_q;
		first_n = first_q;

		st_we    = 1'b0;
		st_waddr = '0;
		st_wdata = pn_pkg::SLASH;
		st_re    = 1'b0;
		st_raddr = AW'(read_index);
		sk_we    = 1'b0;
		sk_waddr = SAW'(ec_cnt);
		sk_wdata = {ec_fill, ec_dd};
		sk_re    = 1'b0;
		sk_raddr = SAW'(ec_cnt - CNTW'(2));

		out_load  = 1'b0;
		ld_status = err_q;
		ld_len    = pn_pkg::LEN_WIDTH'(final_q);
		ld_byte   = '0;

		if (acc_push) begin
			fill_n  = b_fill;
			cnt_n   = b_cnt;
			len_n   = b_len;
			pat_n   = b_pat;
			err_n   = err_a;
			abs_n   = b_abs;
			seen_n  = seen_inc;
			first_n = 1'b0;
			final_n = first_q ? '0 : final_q;
			if (first_q && is_slash) begin
				st_we = 1'b1;
			end
			if (do_char) begin
				if (char_pos < XW'(PATH_CAP)) begin
					st_we    = 1'b1;
					st_waddr = AW'(char_pos);
					st_wdata = path_byte;
				end
				len_n = len_inc;
				if (path_byte == pn_pkg::DOT &&
						(b_pat == pn_pkg::PAT_EMPTY || b_pat == pn_pkg::PAT_DOT)) begin
					pat_n = (b_pat == pn_pkg::PAT_EMPTY) ? pn_pkg::PAT_DOT : pn_pkg::PAT_DOTDOT;
				end else begin
					pat_n = pn_pkg::PAT_OTHER;
				end
				if (len_inc >= LW'(NAME_LIMIT)) begin
					err_n = pn_pkg::STAT_NAME_LONG;
				end
			end
		end

		if (ec_en) begin
			len_n = '0;
			pat_n = pn_pkg::PAT_EMPTY;
			if (do_pop) begin
				cnt_n  = ec_cnt - CNTW'(1);
				fill_n = top_start_q;
				sk_re  = (ec_cnt >= CNTW'(2));
			end
			if (do_ovf) begin
				err_n = pn_pkg::STAT_OVERFLOW;
			end
			if (do_app) begin
				st_we    = 1'b1;
				st_waddr = AW'(ec_sum);
				st_wdata = pn_pkg::SLASH;
				sk_we    = 1'b1;
				cnt_n    = ec_cnt + CNTW'(1);
				fill_n   = FW'(ec_sum + XW'(1));
			end
		end

		if (acc_read) begin
			st_re = 1'b1;
		end

		case (st_q)
			pn_pkg::ST_IDLE: begin
				if (acc_read) begin
					st_n = pn_pkg::ST_RDWAIT;
				end else if (acc_push) begin
					if (do_pop) begin
						st_n = pn_pkg::ST_RELOAD;
					end else if (last_byte) begin
						st_n = pn_pkg::ST_FIN;
					end
				end
			end
			pn_pkg::ST_RELOAD: begin
				st_n = last_q ? pn_pkg::ST_FIN : pn_pkg::ST_IDLE;
			end
			pn_pkg::ST_FIN: begin
				st_n = pn_pkg::ST_DONE;
			end
			pn_pkg::ST_DONE: begin
				if (out_free) begin
					err_n     = done_err;
					final_n   = (done_err == pn_pkg::STAT_OK) ? trim_fill : '0;
					first_n   = 1'b1;
					out_load  = 1'b1;
					ld_status = done_err;
					ld_len    = (done_err == pn_pkg::STAT_OK)
						? pn_pkg::LEN_WIDTH'(trim_fill) : '0;
					st_n      = pn_pkg::ST_IDLE;
				end
			end
			pn_pkg::ST_RDWAIT: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_byte  = rd_hit_q ? st_rdata : 8'd0;
					st_n     = pn_pkg::ST_IDLE;
				end
			end
			default: begin
				st_n = pn_pkg::ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= pn_pkg::ST_IDLE;
			err_q       <= pn_pkg::STAT_OK;
			pat_q       <= pn_pkg::PAT_EMPTY;
			cap_q       <= CW'(CAP_RST);
			fill_q      <= '0;
			cnt_q       <= '0;
			len_q       <= '0;
			seen_q      <= '0;
			final_q     <= '0;
			abs_q       <= 1'b0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			st_q    <= st_n;
			err_q   <= err_n;
			pat_q   <= pat_n;
			fill_q  <= fill_n;
			cnt_q   <= cnt_n;
			len_q   <= len_n;
			seen_q  <= seen_n;
			final_q <= final_n;
			abs_q   <= abs_n;
			first_q <= first_n;
			// capacity is clamped into 1..PATH_CAP on the write
			if (cfg_valid && cfg_ready) begin
				if (output_capacity == '0) begin
					cap_q <= CW'(1);
				end else if (CW'(output_capacity) > CW'(PATH_CAP)) begin
					cap_q <= CW'(PATH_CAP);
				end else begin
					cap_q <= CW'(output_capacity);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_app) begin
			top_start_q <= ec_fill;
			top_dd_q    <= ec_dd;
		end else if (st_q == pn_pkg::ST_RELOAD) begin
			top_start_q <= sk_rdata[FW:1];
			top_dd_q    <= sk_rdata[0];
		end
		if (acc_push) begin
			last_q <= last_byte;
		end
		if (acc_read) begin
			rd_hit_q <= (XW'(read_index) < XW'(final_q));
		end
		if (out_load) begin
			status_q   <= ld_status;
			norm_len_q <= ld_len;
			out_byte_q <= ld_byte;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign norm_length = norm_len_q;
	assign out_byte    = out_byte_q;

	// ------------------------------------------------------------------
	// Memories
	// ------------------------------------------------------------------
	pn_ram #(
		.WIDTH(8),
		.DEPTH(PATH_CAP)
	) u_norm_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	// entry: {component start, component is ".."}
	pn_ram #(
		.WIDTH(FW + 1),
		.DEPTH(SEG_DEPTH)
	) u_seg_ram (
		.clk  (clk),
		.we   (sk_we),
		.waddr(sk_waddr),
		.wdata(sk_wdata),
		.re   (sk_re),
		.raddr(sk_raddr),
		.rdata(sk_rdata)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_pop_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == pn_pkg::ST_IDLE && do_pop) |=> (st_q == pn_pkg::ST_RELOAD))
		else $error("pop not followed by stack top reload");

	a_name_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == pn_pkg::ST_IDLE && !first_q && err_q == pn_pkg::STAT_OK)
		|-> (len_q < LW'(NAME_LIMIT)))
		else $error("component length past limit without error");

	a_final_in_path: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q |-> (final_q == '0))
		else $error("final length not cleared while a path is in progress");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(SEG_DEPTH))
		else $error("segment stack count out of range");

endmodule

`default_nettype wire
